// ===== rtl/core/kabf_pkg.sv =====
// shared types, constants and helpers for the kalman angle and bias filter
// no dependencies
package kabf_pkg;

   localparam int NUM_AXES_DEF  = 3;
   localparam int FRAC_BITS_DEF = 16;

   localparam int AXIS_W     = 2;
   localparam int MEAS_W     = 25;
   localparam int RATE_W     = 28;
   localparam int EST_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 21;
   localparam int APN_W      = 17;
   localparam int BPN_W      = 17;
   localparam int MN_W       = 21;
   localparam int DT_W       = 17;
   localparam int OP_W       = 34;
   localparam int PROD_W     = 2 * OP_W;
   localparam int ACC_W      = PROD_W + 2;
   localparam int DEN_W      = 33;

   localparam logic [APN_W-1:0] APN_RESET = APN_W'(66);
   localparam logic [BPN_W-1:0] BPN_RESET = BPN_W'(197);
   localparam logic [MN_W-1:0]  MN_RESET  = MN_W'(32768);
   localparam logic [DT_W-1:0]  DT_RESET  = DT_W'(655);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANGLE_NOISE,
      CSR_BIAS_NOISE,
      CSR_MEASURE_NOISE,
      CSR_STEP_TIME
   } csr_index_type;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_RATE_DT,
      MUL_SUM_DT,
      MUL_BB_DT,
      MUL_K0_E,
      MUL_K1_E,
      MUL_K0_P00,
      MUL_K0_P01,
      MUL_K1_P00,
      MUL_K1_P01
   } mul_op_type;

   typedef enum logic [3:0] {
      UPD_NONE,
      UPD_ANG_PRED,
      UPD_P00,
      UPD_PRED_REST,
      UPD_ANG,
      UPD_BIAS,
      UPD_AA,
      UPD_AB,
      UPD_BA,
      UPD_BB
   } upd_op_type;

   typedef struct packed {
      logic       take_item;
      logic       load_state;
      mul_op_type mul_op;
      upd_op_type upd_op;
      logic       div_start;
      logic       write_back;
   } ctrl_cmd_type;

   typedef struct packed {
      logic axis_bad;
      logic div_done;
   } dp_status_type;

   function automatic logic signed [EST_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = $signed({{(ACC_W-EST_W){1'b0}}, 32'h7FFF_FFFF});
      lo = $signed({{(ACC_W-EST_W){1'b1}}, 32'h8000_0000});
      if (x > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (x < lo) begin
         return 32'sh8000_0000;
      end else begin
         return x[EST_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/core/kabf_if.sv =====
// request and response channel interfaces of the kalman angle and bias filter
// depends on kabf_pkg
interface kabf_req_if;
   logic                                valid;
   logic                                ready;
   logic [kabf_pkg::AXIS_W-1:0]         axis;
   logic signed [kabf_pkg::MEAS_W-1:0]  measured_angle;
   logic signed [kabf_pkg::RATE_W-1:0]  gyro_rate;
   modport source(output valid, axis, measured_angle, gyro_rate, input ready);
   modport sink(input valid, axis, measured_angle, gyro_rate, output ready);
endinterface

interface kabf_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [kabf_pkg::AXIS_W-1:0]        axis_out;
   logic signed [kabf_pkg::EST_W-1:0]  filtered_angle;
   logic signed [kabf_pkg::EST_W-1:0]  bias_estimate;
   modport source(output valid, axis_out, filtered_angle, bias_estimate, input ready);
   modport sink(input valid, axis_out, filtered_angle, bias_estimate, output ready);
endinterface

// ===== rtl/core/kalman_angle_bias_filter.sv =====
// Kalman angle and gyro-bias filter, one two-state filter per axis. One item is
// worked at a time. The shared gain divider produces one quotient bit per cycle for
// both gains at once, at Q16.16 by default; the one shared multiplier runs through the
// prediction and correction products. The next item is accepted while a result
// waits in the output register. Config writes take effect immediately and belong
// to idle time.
// depends on kabf_pkg, kabf_if, kabf_ctrl, kabf_dp
module kalman_angle_bias_filter #(
   parameter int NUM_AXES  = kabf_pkg::NUM_AXES_DEF,
   parameter int FRAC_BITS = kabf_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [kabf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kabf_pkg::CSR_DATA_W-1:0] csr_wdata,
   kabf_req_if.sink                        req_chan,
   kabf_rsp_if.source                      rsp_chan
);
   kabf_pkg::ctrl_cmd_type  cmd;
   kabf_pkg::dp_status_type stat;

   kabf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   kabf_dp #(.NUM_AXES(NUM_AXES), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .axis           (req_chan.axis),
      .measured_angle (req_chan.measured_angle),
      .gyro_rate      (req_chan.gyro_rate),
      .axis_out       (rsp_chan.axis_out),
      .filtered_angle (rsp_chan.filtered_angle),
      .bias_estimate  (rsp_chan.bias_estimate),
      .cmd            (cmd),
      .stat           (stat)
   );

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("input taken while an item is in progress");

   a_div_not_instant: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !stat.div_done)
      else $error("divider finished too early");

   a_result_presented: assert property (@(posedge clock) disable iff (reset)
      cmd.write_back |=> rsp_chan.valid)
      else $error("write back without a response");
endmodule

// ===== rtl/core/kabf_div.sv =====
// two-lane restoring divider, one quotient bit per cycle, shared divisor
// depends on kabf_pkg
module kabf_div #(
   parameter int FRAC_BITS = kabf_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [kabf_pkg::DEN_W-1:0]       den,
   input  logic [kabf_pkg::EST_W-1:0]       num0_mag,
   input  logic [kabf_pkg::EST_W-1:0]       num1_mag,
   output logic                             done,
   output logic [kabf_pkg::EST_W+FRAC_BITS-1:0] quo0,
   output logic [kabf_pkg::EST_W+FRAC_BITS-1:0] quo1
);
   localparam int QW    = kabf_pkg::EST_W + FRAC_BITS;
   localparam int CNT_W = $clog2(QW + 1);
   localparam int DW    = kabf_pkg::DEN_W;

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DW-1:0]    den_ff;
   logic [DW-1:0]    rem0_ff, rem1_ff;
   logic [QW-1:0]    quo0_ff, quo1_ff;

   logic [DW:0]      rem0_sh, rem1_sh, rem0_in, rem1_in;
   logic             ge0, ge1;

   always_comb begin
      rem0_sh = {rem0_ff, quo0_ff[QW-1]};
      rem1_sh = {rem1_ff, quo1_ff[QW-1]};
      ge0     = rem0_sh >= {1'b0, den_ff};
      ge1     = rem1_sh >= {1'b0, den_ff};
      rem0_in = ge0 ? rem0_sh - {1'b0, den_ff} : rem0_sh;
      rem1_in = ge1 ? rem1_sh - {1'b0, den_ff} : rem1_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(QW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff  <= den;
         rem0_ff <= '0;
         rem1_ff <= '0;
         quo0_ff <= {num0_mag, {FRAC_BITS{1'b0}}};
         quo1_ff <= {num1_mag, {FRAC_BITS{1'b0}}};
      end else if (busy_ff) begin
         rem0_ff <= rem0_in[DW-1:0];
         rem1_ff <= rem1_in[DW-1:0];
         quo0_ff <= {quo0_ff[QW-2:0], ge0};
         quo1_ff <= {quo1_ff[QW-2:0], ge1};
      end
   end

   assign done = done_ff;
   assign quo0 = quo0_ff;
   assign quo1 = quo1_ff;
endmodule

// ===== rtl/core/kabf_dp.sv =====
// datapath: per-axis state, config registers, shared multiplier, gain divider
// depends on kabf_pkg and kabf_div
module kabf_dp #(
   parameter int NUM_AXES  = kabf_pkg::NUM_AXES_DEF,
   parameter int FRAC_BITS = kabf_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [kabf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kabf_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [kabf_pkg::AXIS_W-1:0]        axis,
   input  logic signed [kabf_pkg::MEAS_W-1:0] measured_angle,
   input  logic signed [kabf_pkg::RATE_W-1:0] gyro_rate,
   output logic [kabf_pkg::AXIS_W-1:0]        axis_out,
   output logic signed [kabf_pkg::EST_W-1:0]  filtered_angle,
   output logic signed [kabf_pkg::EST_W-1:0]  bias_estimate,
   input  kabf_pkg::ctrl_cmd_type             cmd,
   output kabf_pkg::dp_status_type            stat
);
   localparam int EW    = kabf_pkg::EST_W;
   localparam int AW    = kabf_pkg::ACC_W;
   localparam int OW    = kabf_pkg::OP_W;
   localparam int PW    = kabf_pkg::PROD_W;
   localparam int QW    = EW + FRAC_BITS;
   localparam int IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

   logic [kabf_pkg::APN_W-1:0] apn_ff;
   logic [kabf_pkg::BPN_W-1:0] bpn_ff;
   logic [kabf_pkg::MN_W-1:0]  mn_ff;
   logic [kabf_pkg::DT_W-1:0]  dt_ff;

   logic signed [EW-1:0] angle_arr_ff [NUM_AXES];
   logic signed [EW-1:0] bias_arr_ff  [NUM_AXES];
   logic signed [EW-1:0] aa_arr_ff    [NUM_AXES];
   logic signed [EW-1:0] ab_arr_ff    [NUM_AXES];
   logic signed [EW-1:0] ba_arr_ff    [NUM_AXES];
   logic signed [EW-1:0] bb_arr_ff    [NUM_AXES];

   logic [kabf_pkg::AXIS_W-1:0]        axis_ff;
   logic signed [kabf_pkg::MEAS_W-1:0] meas_ff;
   logic signed [kabf_pkg::RATE_W-1:0] rate_ff;
   logic signed [EW-1:0] ang_ff, bias_ff, aa_ff, ab_ff, ba_ff, bb_ff;
   logic signed [EW-1:0] p00_ff, p01_ff, p10_ff, p11_ff, e_ff, k0_ff, k1_ff;
   logic signed [PW-1:0] prod_ff;
   logic                 den_pos_ff;
   logic [kabf_pkg::AXIS_W-1:0] axis_out_ff;
   logic signed [EW-1:0] fang_ff, fbias_ff;

   logic [IDX_W-1:0]     idx;
   logic                 axis_bad;
   logic signed [OW-1:0] op_a, op_b, dt_op;
   logic signed [PW-1:0] prod_in;
   logic signed [AW-1:0] sh;
   logic signed [AW-1:0] den_w;
   logic                 den_pos;
   logic [EW-1:0]        mag0, mag1;
   logic                 div_done;
   logic [QW-1:0]        quo0, quo1;

   function automatic logic signed [EW-1:0] gain_sat(input logic [QW-1:0] q, input logic neg);
      if (!neg) begin
         return (q > QW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q[EW-1:0]);
      end else begin
         return (q > QW'(32'h8000_0000)) ? 32'sh8000_0000 : $signed(-q[EW-1:0]);
      end
   endfunction

   assign idx      = IDX_W'(axis_ff);
   assign axis_bad = 32'(axis_ff) >= NUM_AXES;
   assign dt_op    = $signed(OW'(dt_ff));
   assign den_w    = AW'(p00_ff) + $signed(AW'(mn_ff));
   assign den_pos  = den_w > 0;
   assign mag0     = p00_ff[EW-1] ? (~p00_ff) + EW'(1) : p00_ff;
   assign mag1     = p10_ff[EW-1] ? (~p10_ff) + EW'(1) : p10_ff;
   assign sh       = AW'(prod_ff >>> FRAC_BITS);
   assign prod_in  = PW'(op_a) * PW'(op_b);

   assign stat.axis_bad = axis_bad;
   assign stat.div_done = div_done;

   kabf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .den      (den_w[kabf_pkg::DEN_W-1:0]),
      .num0_mag (mag0),
      .num1_mag (mag1),
      .done     (div_done),
      .quo0     (quo0),
      .quo1     (quo1)
   );

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (cmd.mul_op)
         kabf_pkg::MUL_RATE_DT: begin
            op_a = OW'(rate_ff) - OW'(bias_ff);
            op_b = dt_op;
         end
         kabf_pkg::MUL_SUM_DT: begin
            op_a = OW'(ab_ff) + OW'(ba_ff);
            op_b = dt_op;
         end
         kabf_pkg::MUL_BB_DT: begin
            op_a = OW'(bb_ff);
            op_b = dt_op;
         end
         kabf_pkg::MUL_K0_E: begin
            op_a = OW'(k0_ff);
            op_b = OW'(e_ff);
         end
         kabf_pkg::MUL_K1_E: begin
            op_a = OW'(k1_ff);
            op_b = OW'(e_ff);
         end
         kabf_pkg::MUL_K0_P00: begin
            op_a = OW'(k0_ff);
            op_b = OW'(p00_ff);
         end
         kabf_pkg::MUL_K0_P01: begin
            op_a = OW'(k0_ff);
            op_b = OW'(p01_ff);
         end
         kabf_pkg::MUL_K1_P00: begin
            op_a = OW'(k1_ff);
            op_b = OW'(p00_ff);
         end
         kabf_pkg::MUL_K1_P01: begin
            op_a = OW'(k1_ff);
            op_b = OW'(p01_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // config registers and per-axis state
   always_ff @(posedge clock) begin
      if (reset) begin
         apn_ff <= kabf_pkg::APN_RESET;
         bpn_ff <= kabf_pkg::BPN_RESET;
         mn_ff  <= kabf_pkg::MN_RESET;
         dt_ff  <= kabf_pkg::DT_RESET;
         for (int i = 0; i < NUM_AXES; i++) begin
            angle_arr_ff[i] <= '0;
            bias_arr_ff[i]  <= '0;
            aa_arr_ff[i]    <= EW'(1) << FRAC_BITS;
            ab_arr_ff[i]    <= '0;
            ba_arr_ff[i]    <= '0;
            bb_arr_ff[i]    <= EW'(1) << FRAC_BITS;
         end
      end else begin
         if (csr_we) begin
            case (kabf_pkg::csr_index_type'(csr_index))
               kabf_pkg::CSR_ANGLE_NOISE:   apn_ff <= csr_wdata[kabf_pkg::APN_W-1:0];
               kabf_pkg::CSR_BIAS_NOISE:    bpn_ff <= csr_wdata[kabf_pkg::BPN_W-1:0];
               kabf_pkg::CSR_MEASURE_NOISE: mn_ff  <= csr_wdata[kabf_pkg::MN_W-1:0];
               kabf_pkg::CSR_STEP_TIME:     dt_ff  <= csr_wdata[kabf_pkg::DT_W-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.write_back && !axis_bad) begin
            angle_arr_ff[idx] <= ang_ff;
            bias_arr_ff[idx]  <= bias_ff;
            aa_arr_ff[idx]    <= aa_ff;
            ab_arr_ff[idx]    <= ab_ff;
            ba_arr_ff[idx]    <= ba_ff;
            bb_arr_ff[idx]    <= bb_ff;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.take_item) begin
         axis_ff <= axis;
         meas_ff <= measured_angle;
         rate_ff <= gyro_rate;
      end
      if (cmd.load_state) begin
         ang_ff  <= angle_arr_ff[idx];
         bias_ff <= bias_arr_ff[idx];
         aa_ff   <= aa_arr_ff[idx];
         ab_ff   <= ab_arr_ff[idx];
         ba_ff   <= ba_arr_ff[idx];
         bb_ff   <= bb_arr_ff[idx];
      end
      if (cmd.div_start) begin
         den_pos_ff <= den_pos;
      end
      if (div_done) begin
         k0_ff <= den_pos_ff ? gain_sat(quo0, p00_ff[EW-1]) : '0;
         k1_ff <= den_pos_ff ? gain_sat(quo1, p10_ff[EW-1]) : '0;
      end
      case (cmd.upd_op)
         kabf_pkg::UPD_ANG_PRED: ang_ff <= kabf_pkg::sat32(AW'(ang_ff) + sh);
         kabf_pkg::UPD_P00: begin
            p00_ff <= kabf_pkg::sat32(AW'(aa_ff) + $signed(AW'(apn_ff)) - sh);
         end
         kabf_pkg::UPD_PRED_REST: begin
            p01_ff <= kabf_pkg::sat32(AW'(ab_ff) - sh);
            p10_ff <= kabf_pkg::sat32(AW'(ba_ff) - sh);
            p11_ff <= kabf_pkg::sat32(AW'(bb_ff) + $signed(AW'(bpn_ff)));
            e_ff   <= kabf_pkg::sat32(AW'(meas_ff) - AW'(ang_ff));
         end
         kabf_pkg::UPD_ANG:  ang_ff  <= kabf_pkg::sat32(AW'(ang_ff) + sh);
         kabf_pkg::UPD_BIAS: bias_ff <= kabf_pkg::sat32(AW'(bias_ff) + sh);
         kabf_pkg::UPD_AA:   aa_ff   <= kabf_pkg::sat32(AW'(p00_ff) - sh);
         kabf_pkg::UPD_AB:   ab_ff   <= kabf_pkg::sat32(AW'(p01_ff) - sh);
         kabf_pkg::UPD_BA:   ba_ff   <= kabf_pkg::sat32(AW'(p10_ff) - sh);
         kabf_pkg::UPD_BB:   bb_ff   <= kabf_pkg::sat32(AW'(p11_ff) - sh);
         default: begin
         end
      endcase
      if (cmd.write_back) begin
         axis_out_ff <= axis_ff;
         fang_ff     <= axis_bad ? '0 : ang_ff;
         fbias_ff    <= axis_bad ? '0 : bias_ff;
      end
   end

   assign axis_out       = axis_out_ff;
   assign filtered_angle = fang_ff;
   assign bias_estimate  = fbias_ff;
endmodule

// ===== rtl/core/kabf_ctrl.sv =====
// controller: sequences prediction, gain division and correction steps
// depends on kabf_pkg
module kabf_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  kabf_pkg::dp_status_type   stat,
   output kabf_pkg::ctrl_cmd_type    cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_P0, S_P1, S_P2, S_P3, S_DIVGO, S_DIVW,
      S_C0, S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.mul_op     = kabf_pkg::MUL_NONE;
      cmd.upd_op     = kabf_pkg::UPD_NONE;
      cmd.take_item  = (state_ff == S_IDLE) && req_valid;
      cmd.load_state = (state_ff == S_LOAD) && !stat.axis_bad;
      cmd.div_start  = state_ff == S_DIVGO;
      cmd.write_back = (state_ff == S_DONE) && out_free;
      case (state_ff)
         S_P0: cmd.mul_op = kabf_pkg::MUL_RATE_DT;
         S_P1: begin
            cmd.mul_op = kabf_pkg::MUL_SUM_DT;
            cmd.upd_op = kabf_pkg::UPD_ANG_PRED;
         end
         S_P2: begin
            cmd.mul_op = kabf_pkg::MUL_BB_DT;
            cmd.upd_op = kabf_pkg::UPD_P00;
         end
         S_P3: cmd.upd_op = kabf_pkg::UPD_PRED_REST;
         S_C0: cmd.mul_op = kabf_pkg::MUL_K0_E;
         S_C1: begin
            cmd.mul_op = kabf_pkg::MUL_K1_E;
            cmd.upd_op = kabf_pkg::UPD_ANG;
         end
         S_C2: begin
            cmd.mul_op = kabf_pkg::MUL_K0_P00;
            cmd.upd_op = kabf_pkg::UPD_BIAS;
         end
         S_C3: begin
            cmd.mul_op = kabf_pkg::MUL_K0_P01;
            cmd.upd_op = kabf_pkg::UPD_AA;
         end
         S_C4: begin
            cmd.mul_op = kabf_pkg::MUL_K1_P00;
            cmd.upd_op = kabf_pkg::UPD_AB;
         end
         S_C5: begin
            cmd.mul_op = kabf_pkg::MUL_K1_P01;
            cmd.upd_op = kabf_pkg::UPD_BA;
         end
         S_C6: cmd.upd_op = kabf_pkg::UPD_BB;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.write_back || (rsp_valid_ff && !rsp_ready);
         case (state_ff)
            S_IDLE:  if (req_valid) state_ff <= S_LOAD;
            S_LOAD:  state_ff <= stat.axis_bad ? S_DONE : S_P0;
            S_P0:    state_ff <= S_P1;
            S_P1:    state_ff <= S_P2;
            S_P2:    state_ff <= S_P3;
            S_P3:    state_ff <= S_DIVGO;
            S_DIVGO: state_ff <= S_DIVW;
            S_DIVW:  if (stat.div_done) state_ff <= S_C0;
            S_C0:    state_ff <= S_C1;
            S_C1:    state_ff <= S_C2;
            S_C2:    state_ff <= S_C3;
            S_C3:    state_ff <= S_C4;
            S_C4:    state_ff <= S_C5;
            S_C5:    state_ff <= S_C6;
            S_C6:    state_ff <= S_DONE;
            S_DONE: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
